// ===== rtl/sorted_priority_queue_core_assert.svh =====
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Checked on rising clk edges, suppressed while rst is high.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int COUNT_FIELD_W = 5;
  localparam int CMD_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_PUT,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic set_rej;
    logic init_top;
    logic init_bot;
    logic rd;
    logic ins_shift;
    logic ins_place;
    logic put;
    logic rm_step;
    logic fd_step;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic full;
    logic gt;
    logic eq;
    logic idx_zero;
    logic idx_last;
    logic hit;
  } dp_status_t;

endpackage

// ===== rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath: operand, scan index, count, head and result registers plus entry RAM.
`include "sorted_priority_queue_core_assert.svh"

module spq_datapath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::dp_cmd_t                  ctl,
  output spq_pkg::dp_status_t               sts,
  input  logic [spq_pkg::CMD_W-1:0]         cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0] value,
  output logic                              found,
  output logic signed [spq_pkg::VALUE_W-1:0] head_value,
  output logic                              is_empty,
  output logic [spq_pkg::COUNT_FIELD_W-1:0] entry_count,
  output logic                              rejected
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::op_t                       op;
  logic signed [spq_pkg::VALUE_W-1:0] val;
  logic signed [spq_pkg::VALUE_W-1:0] head;
  logic [AW-1:0]                      idx;
  logic [CW-1:0]                      count;
  logic                               hit;
  logic                               found_r;
  logic                               rej_r;

  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  logic [spq_pkg::VALUE_W-1:0]        ram_wdata;
  logic [spq_pkg::VALUE_W-1:0]        ram_rdata;
  logic [AW-1:0]                      idx_inc;
  logic [AW-1:0]                      idx_dec;
  logic [CW-1:0]                      count_last;
  logic                               eq;

  assign idx_inc    = idx + AW'(1);
  assign idx_dec    = idx - AW'(1);
  assign count_last = count - CW'(1);
  assign eq         = (ram_rdata == val);

  always_comb begin
    sts.op         = op;
    sts.count_zero = (count == '0);
    sts.full       = (count == CW'(DEPTH));
    sts.gt         = ($signed(ram_rdata) > val);
    sts.eq         = eq;
    sts.idx_zero   = (idx == '0);
    sts.idx_last   = (CW'(idx) == count_last);
    sts.hit        = hit;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_inc;
    ram_wdata = ram_rdata;
    if (ctl.ins_shift) begin
      ram_we = 1'b1;
    end else if (ctl.ins_place) begin
      ram_we    = 1'b1;
      ram_wdata = val;
    end else if (ctl.put) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = val;
    end else if (ctl.rm_step && hit) begin
      ram_we    = 1'b1;
      ram_waddr = idx_dec;
    end
  end

  spq_ram #(
    .WIDTH(spq_pkg::VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ctl.rd),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins_place || ctl.put) begin
      count <= count + CW'(1);
    end else if (ctl.rm_step && sts.idx_last && (hit || eq)) begin
      count <= count_last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op      <= spq_pkg::op_t'(cmd);
      val     <= value;
      found_r <= 1'b0;
      rej_r   <= 1'b0;
    end
    if (ctl.set_rej) begin
      rej_r <= 1'b1;
    end
    if (ctl.init_top) begin
      idx <= AW'(count_last);
    end else if (ctl.init_bot) begin
      idx <= '0;
      hit <= 1'b0;
    end else if (ctl.ins_shift) begin
      idx <= idx_dec;
    end else if (ctl.rm_step) begin
      idx <= idx_inc;
      hit <= hit | eq;
      if (sts.idx_last && (hit || eq)) begin
        found_r <= 1'b1;
      end
    end else if (ctl.fd_step) begin
      idx     <= idx_inc;
      found_r <= found_r | eq;
    end
    // head tracks every write to entry 0
    if (ram_we && (ram_waddr == '0)) begin
      head <= $signed(ram_wdata);
    end
    if (ctl.load_out) begin
      found       <= found_r;
      head_value  <= (count == '0) ? '0 : head;
      is_empty    <= (count == '0);
      entry_count <= spq_pkg::COUNT_FIELD_W'(count);
      rejected    <= rej_r;
    end
  end

  `SPQ_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count exceeds depth")
  `SPQ_ASSERT(a_put_grows, ctl.put |=> count == $past(count) + CW'(1), "put did not grow count")
  `SPQ_ASSERT(a_rej_full, ctl.set_rej |-> sts.full, "insert rejected while not full")

endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller: sequences dispatch, RAM scans and result hand-off.
`include "sorted_priority_queue_core_assert.svh"

module spq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  spq_pkg::dp_status_t sts,
  output spq_pkg::dp_cmd_t    ctl
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != spq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (in_valid) state_next = spq_pkg::ST_DISPATCH;
      end
      spq_pkg::ST_DISPATCH: begin
        unique case (sts.op) inside
          spq_pkg::OP_INSERT: begin
            if (sts.full)            state_next = spq_pkg::ST_DONE;
            else if (sts.count_zero) state_next = spq_pkg::ST_PUT;
            else                     state_next = spq_pkg::ST_READ;
          end
          spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: begin
            state_next = sts.count_zero ? spq_pkg::ST_DONE : spq_pkg::ST_READ;
          end
          default: state_next = spq_pkg::ST_DONE;
        endcase
      end
      spq_pkg::ST_READ: state_next = spq_pkg::ST_EVAL;
      spq_pkg::ST_EVAL: begin
        unique case (sts.op)
          spq_pkg::OP_INSERT: begin
            if (!sts.gt)          state_next = spq_pkg::ST_DONE;
            else if (sts.idx_zero) state_next = spq_pkg::ST_PUT;
            else                  state_next = spq_pkg::ST_READ;
          end
          spq_pkg::OP_REMOVE: begin
            state_next = sts.idx_last ? spq_pkg::ST_DONE : spq_pkg::ST_READ;
          end
          default: begin
            state_next = (sts.eq || sts.idx_last) ? spq_pkg::ST_DONE : spq_pkg::ST_READ;
          end
        endcase
      end
      spq_pkg::ST_PUT: state_next = spq_pkg::ST_DONE;
      spq_pkg::ST_DONE: begin
        if (out_free) state_next = spq_pkg::ST_IDLE;
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      spq_pkg::ST_IDLE: ctl.capture = in_valid;
      spq_pkg::ST_DISPATCH: begin
        unique case (sts.op) inside
          spq_pkg::OP_INSERT: begin
            ctl.set_rej  = sts.full;
            ctl.init_top = !sts.full && !sts.count_zero;
          end
          spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: ctl.init_bot = !sts.count_zero;
          default: ;
        endcase
      end
      spq_pkg::ST_READ: ctl.rd = 1'b1;
      spq_pkg::ST_EVAL: begin
        unique case (sts.op)
          spq_pkg::OP_INSERT: begin
            ctl.ins_shift = sts.gt;
            ctl.ins_place = !sts.gt;
          end
          spq_pkg::OP_REMOVE: ctl.rm_step = 1'b1;
          default:            ctl.fd_step = 1'b1;
        endcase
      end
      spq_pkg::ST_PUT:  ctl.put = 1'b1;
      spq_pkg::ST_DONE: ctl.load_out = out_free;
      default: ;
    endcase
  end

  `SPQ_ASSERT(a_accept_dispatch, in_valid && !in_stall |=> state == spq_pkg::ST_DISPATCH,
              "transfer not followed by dispatch")
  `SPQ_ASSERT(a_read_eval, state == spq_pkg::ST_READ |=> state == spq_pkg::ST_EVAL,
              "RAM read not followed by evaluate")
  `SPQ_ASSERT(a_result_shown, ctl.load_out |=> out_valid, "loaded result not presented")

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue: a bounded multiset of signed values kept in ascending order.
//
// Input channel (in_valid/in_stall, fields cmd, value): one transfer per operation;
//   cmd selects insert, remove one occurrence, find or peek head.
// Output channel (out_valid/out_stall): exactly one result per input, in order,
//   with found, head_value, is_empty, entry_count and rejected after the operation.
// Entries live in a DEPTH-entry RAM with registered read; one item is worked on at a
//   time and in_stall stays high from the accepting edge until its result is loaded.
// Scan order: inserts read from the top entry down, moving each greater entry up, until
//   one is not greater or the head is reached (then ST_PUT writes the head); removes
//   visit every entry; finds stop at the first match. Peek, a rejected insert and
//   remove/find on an empty store visit no entry; an insert into an empty store goes
//   straight to ST_PUT. Each entry visited costs a RAM read state followed by an
//   evaluate/write state.
// Output register: a new item may be accepted while the previous result waits; the
//   next result is loaded only once the output register is free, so a stalled
//   receiver holds the block in its final state.
// Reset (rst, synchronous): store empties at once, no clearing pass; output invalid.
module sorted_priority_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [spq_pkg::CMD_W-1:0]          cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic signed [spq_pkg::VALUE_W-1:0] head_value,
  output logic                               is_empty,
  output logic [spq_pkg::COUNT_FIELD_W-1:0]  entry_count,
  output logic                               rejected
);

  spq_pkg::dp_cmd_t    ctl;
  spq_pkg::dp_status_t sts;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  spq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .value      (value),
    .found      (found),
    .head_value (head_value),
    .is_empty   (is_empty),
    .entry_count(entry_count),
    .rejected   (rejected)
  );

endmodule

// ===== tb/tb_sorted_priority_queue_core.sv =====
// Self-checking testbench for sorted_priority_queue_core: shadow queue predictor, random traffic.
module tb_sorted_priority_queue_core;

  localparam int QDEPTH        = spq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 1422;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int HOLD_AT_ITEM  = 700;
  localparam int HOLD_CYCLES   = 400;

  typedef logic signed [spq_pkg::VALUE_W-1:0] qvalue_t;

  typedef struct {
    logic                              found;
    qvalue_t                           head;
    logic                              is_empty;
    logic [spq_pkg::COUNT_FIELD_W-1:0] count;
    logic                              rejected;
  } queue_result_t;

  class queue_shadow;
    qvalue_t       slots[$];
    queue_result_t pending[$];

    function void apply_op(spq_pkg::op_t op, qvalue_t v);
      queue_result_t r;
      int            pos;
      r.found    = 1'b0;
      r.rejected = 1'b0;
      pos        = 0;
      case (op) inside
        spq_pkg::OP_INSERT: begin
          if (slots.size() >= QDEPTH) begin
            r.rejected = 1'b1;
          end else begin
            while (pos < slots.size() && slots[pos] <= v) pos++;
            slots.insert(pos, v);
          end
        end
        spq_pkg::OP_REMOVE, spq_pkg::OP_FIND: begin
          while (pos < slots.size() && slots[pos] != v) pos++;
          if (pos < slots.size()) begin
            r.found = 1'b1;
            if (op == spq_pkg::OP_REMOVE) slots.delete(pos);
          end
        end
        default: ;
      endcase
      r.head     = (slots.size() > 0) ? slots[0] : '0;
      r.is_empty = (slots.size() == 0);
      r.count    = spq_pkg::COUNT_FIELD_W'(slots.size());
      pending.push_back(r);
    endfunction

    function bit check_result(queue_result_t got, output string msg);
      queue_result_t exp;
      msg = "";
      if (pending.size() == 0) begin
        msg = "result with no transfer pending";
        return 1'b0;
      end
      exp = pending.pop_front();
      if (got.found !== exp.found)
        msg = {msg, $sformatf(" found %0b exp %0b", got.found, exp.found)};
      if (got.head !== exp.head)
        msg = {msg, $sformatf(" head_value %0d exp %0d", got.head, exp.head)};
      if (got.is_empty !== exp.is_empty)
        msg = {msg, $sformatf(" is_empty %0b exp %0b", got.is_empty, exp.is_empty)};
      if (got.count !== exp.count)
        msg = {msg, $sformatf(" entry_count %0d exp %0d", got.count, exp.count)};
      if (got.rejected !== exp.rejected)
        msg = {msg, $sformatf(" rejected %0b exp %0b", got.rejected, exp.rejected)};
      return (msg == "");
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [spq_pkg::CMD_W-1:0]         cmd = spq_pkg::OP_PEEK;
  qvalue_t                           value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              found;
  qvalue_t                           head_value;
  logic                              is_empty;
  logic [spq_pkg::COUNT_FIELD_W-1:0] entry_count;
  logic                              rejected;

  queue_shadow shadow;
  int          n_accepted = 0;
  int          n_results  = 0;
  int          n_errors   = 0;
  int          idle_cycles = 0;

  sorted_priority_queue_core #(.DEPTH(QDEPTH)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .head_value(head_value), .is_empty(is_empty),
    .entry_count(entry_count), .rejected(rejected)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("mismatch at result %0d:%s", n_results, msg);
  endtask

  task automatic push_op(spq_pkg::op_t op, qvalue_t v);
    @(negedge clk);
    in_valid = 1'b1;
    cmd      = op;
    value    = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.apply_op(op, v);
    n_accepted++;
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic qvalue_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return qvalue_t'(int'($urandom_range(0, 15)) - 8);
    if (sel == 5) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return '1;
      endcase
    end
    return qvalue_t'($urandom);
  endfunction

  function automatic spq_pkg::op_t pick_op(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 55) return spq_pkg::OP_INSERT;
      if (r < 70) return spq_pkg::OP_REMOVE;
      if (r < 88) return spq_pkg::OP_FIND;
      return spq_pkg::OP_PEEK;
    end
    if (r < 20) return spq_pkg::OP_INSERT;
    if (r < 62) return spq_pkg::OP_REMOVE;
    if (r < 88) return spq_pkg::OP_FIND;
    return spq_pkg::OP_PEEK;
  endfunction

  task automatic random_op(bit filling);
    spq_pkg::op_t op;
    qvalue_t      v;
    op = pick_op(filling);
    v  = pick_value();
    if ((op == spq_pkg::OP_REMOVE || op == spq_pkg::OP_FIND) && shadow.slots.size() > 0 &&
        $urandom_range(0, 9) < 6)
      v = shadow.slots[$urandom_range(0, shadow.slots.size() - 1)];
    push_op(op, v);
  endtask

  // receiver stall pattern, with one long hold-off to back the block up
  initial begin
    int  mode;
    int  len;
    int  period;
    bit  held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && n_accepted >= HOLD_AT_ITEM) begin
        held_off = 1'b1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode   = $urandom_range(0, 3);
      len    = $urandom_range(20, 200);
      period = $urandom_range(2, 7);
      for (int i = 0; i < len; i++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 1) == 0);
          2: out_stall = ($urandom_range(0, 99) < 85);
          default: out_stall = ((i % period) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t got;
    string         msg;
    if (!rst && out_valid && !out_stall) begin
      got.found    = found;
      got.head     = head_value;
      got.is_empty = is_empty;
      got.count    = entry_count;
      got.rejected = rejected;
      if (!shadow.check_result(got, msg)) report_mismatch(msg);
      n_results++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_sorted_priority_queue_core: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int burst;
    int phase_left;
    bit filling;
    shadow = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store, extremes, duplicates, hits and misses
    push_op(spq_pkg::OP_PEEK, '0);
    push_op(spq_pkg::OP_REMOVE, 32'sd5);
    push_op(spq_pkg::OP_FIND, 32'sd5);
    push_op(spq_pkg::OP_INSERT, 32'sh7fff_ffff);
    push_op(spq_pkg::OP_INSERT, 32'sh8000_0000);
    push_op(spq_pkg::OP_INSERT, '0);
    push_op(spq_pkg::OP_INSERT, '1);
    push_op(spq_pkg::OP_INSERT, '0);
    push_op(spq_pkg::OP_FIND, '0);
    push_op(spq_pkg::OP_FIND, 32'sd5);
    push_op(spq_pkg::OP_REMOVE, '0);
    push_op(spq_pkg::OP_REMOVE, 32'sd7);
    push_op(spq_pkg::OP_PEEK, 32'sh5a5a_a5a5);
    // fill to capacity, then one insert too many
    for (int i = 0; i < QDEPTH - 4; i++) push_op(spq_pkg::OP_INSERT, qvalue_t'(i * 37 - 200));
    push_op(spq_pkg::OP_INSERT, 32'sd1);
    push_op(spq_pkg::OP_REMOVE, 32'sh8000_0000);
    push_op(spq_pkg::OP_REMOVE, 32'sh7fff_ffff);

    sent       = 0;
    filling    = 1'b1;
    phase_left = $urandom_range(30, 120);
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        random_op(filling);
        sent++;
        phase_left--;
        if (phase_left <= 0) begin
          filling    = ~filling;
          phase_left = $urandom_range(30, 120);
        end
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && shadow.pending.size() == 0) begin
      $display("tb_sorted_priority_queue_core: done, clean");
    end else begin
      $display("tb_sorted_priority_queue_core: done, errors");
    end
    $finish;
  end

endmodule
